### rtl/pbrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and helpers for the periodic box region classifier.
// No dependencies; imported by every module of the block but pbrc_checker.
package pbrc_pkg;

  // coordinate format: unsigned fixed point, one word per axis
  localparam int COORD_BITS = 20;
  localparam int NUM_AXES   = 3;
  localparam int PACK_BITS  = NUM_AXES * COORD_BITS;
  // signed working width: holds -2*2^C .. 3*2^C without overflow
  localparam int CALC_BITS  = COORD_BITS + 3;
  localparam int CLS_BITS   = 2;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [COORD_BITS-1:0]       coord_t;
  typedef logic signed [CALC_BITS-1:0] calc_t;
  typedef logic [CLS_BITS-1:0]         cls_t;

  // resolution classes
  localparam cls_t CLS_FULL   = 2'd0;
  localparam cls_t CLS_HYBRID = 2'd1;

  // configuration register map
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_REGION_LOW    = 3'd0,
    REG_REGION_HIGH   = 3'd1,
    REG_SHELL_WIDTH   = 3'd2,
    REG_DOMAIN_LENGTH = 3'd3,
    REG_CUTOFF_RADIUS = 3'd4
  } cfg_reg_e;

  // live configuration, one coordinate per axis except the single cutoff radius
  typedef struct packed {
    coord_t [NUM_AXES-1:0] lo;
    coord_t [NUM_AXES-1:0] hi;
    coord_t [NUM_AXES-1:0] sh;
    coord_t [NUM_AXES-1:0] len;
    coord_t                cut;
  } cfg_t;

  // one axis worth of candidate boxes, half-open [lo, hi)
  typedef struct packed {
    calc_t lo0;
    calc_t hi0;
    calc_t lo1;
    calc_t hi1;
    logic  use1;
  } axis_box_t;

  // item leaving the bounds stages
  typedef struct packed {
    logic                     valid;
    coord_t    [NUM_AXES-1:0] pos;
    axis_box_t [NUM_AXES-1:0] box;
  } box_item_t;

  // zero extend a coordinate into the signed working width
  function automatic calc_t ext(coord_t v);
    return calc_t'({{(CALC_BITS-COORD_BITS){1'b0}}, v});
  endfunction

endpackage
`default_nettype wire

### rtl/pbrc_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// Configuration register file: decodes writes and unpacks per-axis fields.
// Depends on pbrc_pkg.
module pbrc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [pbrc_pkg::CFG_IDX_BITS-1:0] wr_index_i,
  input  logic [pbrc_pkg::PACK_BITS-1:0]    wr_data_i,
  output pbrc_pkg::cfg_t                    cfg_o
);
  import pbrc_pkg::*;

  cfg_t                  cfg_q, cfg_d;
  coord_t [NUM_AXES-1:0] wr_axes;

  // split packed write data into axes, x in the low bits
  always_comb begin
    for (int d = 0; d < NUM_AXES; d++) begin
      wr_axes[d] = wr_data_i[d*COORD_BITS +: COORD_BITS];
    end
  end

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_reg_e'(wr_index_i))
        REG_REGION_LOW:    cfg_d.lo  = wr_axes;
        REG_REGION_HIGH:   cfg_d.hi  = wr_axes;
        REG_SHELL_WIDTH:   cfg_d.sh  = wr_axes;
        REG_DOMAIN_LENGTH: cfg_d.len = wr_axes;
        REG_CUTOFF_RADIUS: cfg_d.cut = wr_axes[0];
        default:           cfg_d     = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

### rtl/pbrc_bounds.sv
`timescale 1ns / 1ps
`default_nettype none
// Two pipeline stages that turn the region setup into per-axis candidate boxes:
// first the edge sums and fit checks, then box selection. Depends on pbrc_pkg.
module pbrc_bounds (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  pbrc_pkg::cfg_t                             cfg_i,
  input  logic                                       valid_i,
  input  pbrc_pkg::coord_t [pbrc_pkg::NUM_AXES-1:0]  pos_i,
  input  pbrc_pkg::cls_t                             cls_i,
  output pbrc_pkg::box_item_t                        item_o
);
  import pbrc_pkg::*;

  // stage b registers
  logic                  b_valid_q;
  coord_t [NUM_AXES-1:0] b_pos_q;
  calc_t  [NUM_AXES-1:0] b_el_q, b_eh_q, b_ehl_q, b_ell_q, b_dlo_q, b_dhi_q;
  logic   [NUM_AXES-1:0] b_fits_q;
  logic                  b_direct_q;

  calc_t  [NUM_AXES-1:0] b_el_d, b_eh_d, b_ehl_d, b_ell_d, b_dlo_d, b_dhi_d;
  logic   [NUM_AXES-1:0] b_fits_d;
  logic                  b_direct_d;

  // stage c register
  box_item_t c_item_q, c_item_d;

  // edge sums: shell-widened edges, wrap offsets and cutoff-widened direct box
  always_comb begin
    logic  hybrid;
    calc_t lo_e, hi_e, sh_e, len_e, ssh, bo;
    hybrid = (cls_i == CLS_HYBRID);
    for (int d = 0; d < NUM_AXES; d++) begin
      lo_e  = ext(cfg_i.lo[d]);
      hi_e  = ext(cfg_i.hi[d]);
      sh_e  = ext(cfg_i.sh[d]);
      len_e = ext(cfg_i.len[d]);
      ssh   = hybrid ? sh_e : '0;
      bo    = (cfg_i.sh[d] == '0) ? ext(cfg_i.cut) : '0;
      b_el_d[d]   = lo_e - ssh;
      b_eh_d[d]   = hi_e + ssh;
      b_ehl_d[d]  = hi_e + ssh - len_e;
      b_ell_d[d]  = lo_e - ssh + len_e;
      b_dlo_d[d]  = lo_e - ssh - bo;
      b_dhi_d[d]  = hi_e + ssh + bo;
      b_fits_d[d] = (cfg_i.lo[d] >= cfg_i.sh[d]) && (hi_e + sh_e <= len_e);
    end
    b_direct_d = (&b_fits_d) && ((cls_i == CLS_FULL) || hybrid);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    b_pos_q    <= pos_i;
    b_el_q     <= b_el_d;
    b_eh_q     <= b_eh_d;
    b_ehl_q    <= b_ehl_d;
    b_ell_q    <= b_ell_d;
    b_dlo_q    <= b_dlo_d;
    b_dhi_q    <= b_dhi_d;
    b_fits_q   <= b_fits_d;
    b_direct_q <= b_direct_d;
  end

  // box selection: direct box, or clipped box plus wrapped image
  always_comb begin
    calc_t len_e;
    logic  below;
    c_item_d.valid = b_valid_q;
    c_item_d.pos   = b_pos_q;
    for (int d = 0; d < NUM_AXES; d++) begin
      len_e = ext(cfg_i.len[d]);
      below = b_el_q[d][CALC_BITS-1];
      if (b_direct_q) begin
        c_item_d.box[d].lo0  = b_dlo_q[d];
        c_item_d.box[d].hi0  = b_dhi_q[d];
        c_item_d.box[d].lo1  = '0;
        c_item_d.box[d].hi1  = '0;
        c_item_d.box[d].use1 = 1'b0;
      end else begin
        c_item_d.box[d].lo0  = below ? '0 : b_el_q[d];
        c_item_d.box[d].hi0  = (b_eh_q[d] < len_e) ? b_eh_q[d] : len_e;
        c_item_d.box[d].lo1  = below ? b_ell_q[d] : '0;
        c_item_d.box[d].hi1  = (below ? len_e : '0)
                             + ((b_ehl_q[d] > 0) ? b_ehl_q[d] : '0);
        c_item_d.box[d].use1 = !b_fits_q[d];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_item_q <= '0;
    end else begin
      c_item_q <= c_item_d;
    end
  end

  assign item_o = c_item_q;

endmodule
`default_nettype wire

### rtl/pbrc_test.sv
`timescale 1ns / 1ps
`default_nettype none
// Final stage: point-in-box compares per axis, combined into the registered result.
// Depends on pbrc_pkg.
module pbrc_test (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbrc_pkg::box_item_t item_i,
  output logic                done_o,
  output logic                inside_o
);
  import pbrc_pkg::*;

  logic done_q, inside_q, inside_d;

  // per-axis hit on either box, all axes must hit
  always_comb begin
    calc_t p;
    logic  hit0, hit1;
    inside_d = item_i.valid;
    for (int d = 0; d < NUM_AXES; d++) begin
      p    = ext(item_i.pos[d]);
      hit0 = (p >= item_i.box[d].lo0) && (p < item_i.box[d].hi0);
      hit1 = item_i.box[d].use1 && (p >= item_i.box[d].lo1) && (p < item_i.box[d].hi1);
      inside_d = inside_d && (hit0 || hit1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      done_q   <= item_i.valid;
      inside_q <= inside_d;
    end
  end

  assign done_o   = done_q;
  assign inside_o = inside_q;

endmodule
`default_nettype wire

### rtl/periodic_box_region_classifier_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Periodic box region classifier. One position is taken every clock cycle (busy_o
// stays low) and its answer is strobed on inside_res_o with done_o once it has
// passed, in order, the input register, edge sums, box selection and compare
// registers. The strobe lasts one cycle and cannot be held off. Register writes
// take effect on the next cycle and apply to every item in flight that has not
// yet left box selection, so write them only with the pipeline empty.
// Depends on pbrc_pkg, pbrc_cfg_regs, pbrc_bounds and pbrc_test.
module periodic_box_region_classifier_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  pbrc_pkg::coord_t                  pos_x_i,
  input  pbrc_pkg::coord_t                  pos_y_i,
  input  pbrc_pkg::coord_t                  pos_z_i,
  input  pbrc_pkg::cls_t                    resolution_class_i,
  output logic                              done_o,
  output logic                              inside_res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pbrc_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [pbrc_pkg::PACK_BITS-1:0]    cfg_data_i
);
  import pbrc_pkg::*;

  cfg_t                  cfg;
  box_item_t             box_item;
  logic                  a_valid_q;
  coord_t [NUM_AXES-1:0] a_pos_q;
  cls_t                  a_cls_q;

  // always ready on both channels
  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  pbrc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // input register stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    a_pos_q <= {pos_z_i, pos_y_i, pos_x_i};
    a_cls_q <= resolution_class_i;
  end

  pbrc_bounds u_bounds (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (a_valid_q),
    .pos_i   (a_pos_q),
    .cls_i   (a_cls_q),
    .item_o  (box_item)
  );

  pbrc_test u_test (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (box_item),
    .done_o   (done_o),
    .inside_o (inside_res_o)
  );

endmodule
`default_nettype wire

### rtl/pbrc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the classifier core, attached by the bind below.
// Depends on periodic_box_region_classifier_core port names.
module pbrc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o,
  input logic inside_res_o
);

  // every accepted item is answered with a done_o strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o)
    else $error("accepted item not answered after four cycles");

  // no answer without a matching accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 4))
    else $error("result strobe without a matching item");

  // result bit is quiet outside the strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !inside_res_o)
    else $error("inside_res_o set without done_o");

endmodule

bind periodic_box_region_classifier_core pbrc_checker u_pbrc_checker (.*);
`default_nettype wire
